// ----- sv/arpc_pkg.sv -----
// Shared types and constants for the single-entry ARP cache engine.
// No dependencies; used by arpc_engine and the top level.
package arpc_pkg;

   localparam int MacWidth = 48;
   localparam int IpWidth  = 32;
   localparam int TickWidth = 16;
   localparam int RetryWidth = 8;
   localparam int CsrIndexWidth = 3;

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_FRAME    = 2'd1;
   localparam logic [1:0] KIND_QUERY    = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [2:0] RC_NONE    = 3'd0;
   localparam logic [2:0] RC_REQUEST = 3'd1;
   localparam logic [2:0] RC_REPLY   = 3'd2;
   localparam logic [2:0] RC_HIT     = 3'd3;
   localparam logic [2:0] RC_MISS    = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CSR_LOCAL_MAC       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LOCAL_IP        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_OK_TIMEOUT      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PENDING_TIMEOUT = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_RETRIES     = 3'd4;

   localparam logic [TickWidth-1:0]  OK_TIMEOUT_RESET      = 16'd100;
   localparam logic [TickWidth-1:0]  PENDING_TIMEOUT_RESET = 16'd10;
   localparam logic [RetryWidth-1:0] MAX_RETRIES_RESET     = 8'd3;

   localparam logic [10:0] MIN_FRAME_LEN   = 11'd42;
   localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
   localparam logic [15:0] HW_TYPE_ETH     = 16'd1;
   localparam logic [15:0] PROTO_ID_IPV4   = 16'h0800;
   localparam logic [7:0]  HW_LEN_ETH      = 8'd6;
   localparam logic [7:0]  PRO_LEN_IPV4    = 8'd4;
   localparam logic [15:0] OP_REQUEST      = 16'd1;
   localparam logic [15:0] OP_REPLY        = 16'd2;

   typedef enum logic [2:0] {
      ST_FREE      = 3'b001,
      ST_OK        = 3'b010,
      ST_RESOLVING = 3'b100
   } status_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [15:0]         ethertype;
      logic [10:0]         frame_len;
      logic [15:0]         hw_type;
      logic [15:0]         proto_id;
      logic [7:0]          hw_len;
      logic [7:0]          pro_len;
      logic [15:0]         opcode;
      logic [MacWidth-1:0] src_mac;
      logic [IpWidth-1:0]  src_ip;
      logic [IpWidth-1:0]  dst_ip;
      logic [IpWidth-1:0]  query_ip;
   } item_type;

   typedef struct packed {
      logic [2:0]          result_code;
      logic [IpWidth-1:0]  out_dst_ip;
      logic [MacWidth-1:0] out_dst_mac;
      logic [MacWidth-1:0] found_mac;
   } result_type;

   typedef struct packed {
      logic [MacWidth-1:0]   local_mac;
      logic [IpWidth-1:0]    local_ip;
      logic [TickWidth-1:0]  ok_timeout_ticks;
      logic [TickWidth-1:0]  pending_timeout_ticks;
      logic [RetryWidth-1:0] max_retries;
   } cfg_type;

endpackage

// ----- sv/arp_responder_single_entry_cache_unit.sv -----
// Top level of the single-entry ARP cache engine: handshakes, registers, buffers.
// Depends on arpc_pkg and arpc_engine.
//
// Every accepted item yields exactly one result item on rsp_valid, once it has passed
// the input register and then the result register. The input register feeds the decision
// logic, which writes the cache entry and the result register at the same edge, so one
// item per cycle is sustained while rsp_ready stays high. The input register keeps taking
// one more item while a finished result waits on rsp_ready; req_ready drops only when
// both registers are full. Configuration writes are registered and are meant for idle periods.
module arp_responder_single_entry_cache_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_kind,
   input  logic [15:0]  req_ethertype,
   input  logic [10:0]  req_frame_len,
   input  logic [15:0]  req_hw_type,
   input  logic [15:0]  req_proto_id,
   input  logic [7:0]   req_hw_len,
   input  logic [7:0]   req_pro_len,
   input  logic [15:0]  req_opcode,
   input  logic [47:0]  req_src_mac,
   input  logic [31:0]  req_src_ip,
   input  logic [31:0]  req_dst_ip,
   input  logic [31:0]  req_query_ip,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_result_code,
   output logic [31:0]  rsp_out_dst_ip,
   output logic [47:0]  rsp_out_dst_mac,
   output logic [47:0]  rsp_found_mac,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata
);
   import arpc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   in_item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type eng_result;
   logic       advance;
   logic       fire;
   logic       req_fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOCAL_MAC:       cfg_in.local_mac = csr_wdata;
            CSR_LOCAL_IP:        cfg_in.local_ip = csr_wdata[IpWidth-1:0];
            CSR_OK_TIMEOUT:      cfg_in.ok_timeout_ticks = csr_wdata[TickWidth-1:0];
            CSR_PENDING_TIMEOUT: cfg_in.pending_timeout_ticks = csr_wdata[TickWidth-1:0];
            CSR_MAX_RETRIES:     cfg_in.max_retries = csr_wdata[RetryWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_mac             <= '0;
         cfg_ff.local_ip              <= '0;
         cfg_ff.ok_timeout_ticks      <= OK_TIMEOUT_RESET;
         cfg_ff.pending_timeout_ticks <= PENDING_TIMEOUT_RESET;
         cfg_ff.max_retries           <= MAX_RETRIES_RESET;
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.kind      <= req_kind;
         in_item_ff.ethertype <= req_ethertype;
         in_item_ff.frame_len <= req_frame_len;
         in_item_ff.hw_type   <= req_hw_type;
         in_item_ff.proto_id  <= req_proto_id;
         in_item_ff.hw_len    <= req_hw_len;
         in_item_ff.pro_len   <= req_pro_len;
         in_item_ff.opcode    <= req_opcode;
         in_item_ff.src_mac   <= req_src_mac;
         in_item_ff.src_ip    <= req_src_ip;
         in_item_ff.dst_ip    <= req_dst_ip;
         in_item_ff.query_ip  <= req_query_ip;
      end
      if (fire) begin
         rsp_data_ff <= eng_result;
      end
   end

   arpc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (eng_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_data_ff.result_code;
   assign rsp_out_dst_ip  = rsp_data_ff.out_dst_ip;
   assign rsp_out_dst_mac = rsp_data_ff.out_dst_mac;
   assign rsp_found_mac   = rsp_data_ff.found_mac;

   a_pending_item_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("pending item lost while result stalled");

   a_item_reaches_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed item did not produce a result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled with room available");

endmodule

// ----- sv/arpc_engine.sv -----
// Cache entry state and per-item decision logic of the ARP engine.
// Depends on arpc_pkg for item, result, config and status types.
module arpc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  arpc_pkg::item_type  item,
   input  arpc_pkg::cfg_type   cfg,
   output arpc_pkg::result_type result
);
   import arpc_pkg::*;

   status_type             entry_status_ff, entry_status_in;
   logic [IpWidth-1:0]     entry_ip_ff, entry_ip_in;
   logic [MacWidth-1:0]    entry_mac_ff, entry_mac_in;
   logic [TickWidth-1:0]   ticks_left_ff, ticks_left_in;
   logic [RetryWidth-1:0]  retries_left_ff, retries_left_in;

   logic [TickWidth-1:0] ticks_dec;
   logic                 frame_ok;
   logic                 entry_live_ok;

   assign ticks_dec = ticks_left_ff - TickWidth'(1);
   assign entry_live_ok = (entry_status_ff == ST_OK);

   assign frame_ok = (item.frame_len >= MIN_FRAME_LEN)
                  && (item.ethertype == ETHERTYPE_ARP)
                  && (item.hw_type == HW_TYPE_ETH)
                  && (item.proto_id == PROTO_ID_IPV4)
                  && (item.hw_len == HW_LEN_ETH)
                  && (item.pro_len == PRO_LEN_IPV4)
                  && ((item.opcode == OP_REQUEST) || (item.opcode == OP_REPLY))
                  && (item.dst_ip == cfg.local_ip);

   always_comb begin
      entry_status_in = entry_status_ff;
      entry_ip_in     = entry_ip_ff;
      entry_mac_in    = entry_mac_ff;
      ticks_left_in   = ticks_left_ff;
      retries_left_in = retries_left_ff;
      result          = '0;
      result.result_code = RC_NONE;
      case (item.kind)
         KIND_TICK: begin
            case (entry_status_ff)
               ST_OK: begin
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     entry_status_in      = ST_RESOLVING;
                     ticks_left_in        = cfg.pending_timeout_ticks;
                     result.result_code   = RC_REQUEST;
                     result.out_dst_ip    = entry_ip_ff;
                  end
               end
               ST_RESOLVING: begin
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     if (retries_left_ff == '0) begin
                        entry_status_in = ST_FREE;
                     end else begin
                        retries_left_in      = retries_left_ff - RetryWidth'(1);
                        ticks_left_in        = cfg.pending_timeout_ticks;
                        result.result_code   = RC_REQUEST;
                        result.out_dst_ip    = entry_ip_ff;
                     end
                  end
               end
               ST_FREE: begin
               end
               default: begin
                  entry_status_in = ST_FREE;
               end
            endcase
         end
         KIND_FRAME: begin
            if (frame_ok) begin
               if (item.opcode == OP_REQUEST) begin
                  result.result_code = RC_REPLY;
                  result.out_dst_ip  = item.src_ip;
                  result.out_dst_mac = item.src_mac;
               end
               entry_status_in = ST_OK;
               entry_ip_in     = item.src_ip;
               entry_mac_in    = item.src_mac;
               ticks_left_in   = cfg.ok_timeout_ticks;
               retries_left_in = cfg.max_retries;
            end
         end
         KIND_QUERY: begin
            if (entry_live_ok && (entry_ip_ff == item.query_ip)) begin
               result.result_code = RC_HIT;
               result.found_mac   = entry_mac_ff;
            end else begin
               result.result_code = RC_MISS;
               result.out_dst_ip  = item.query_ip;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_status_ff <= ST_FREE;
         entry_ip_ff     <= '0;
         entry_mac_ff    <= '0;
         ticks_left_ff   <= '0;
         retries_left_ff <= '0;
      end else if (fire) begin
         entry_status_ff <= entry_status_in;
         entry_ip_ff     <= entry_ip_in;
         entry_mac_ff    <= entry_mac_in;
         ticks_left_ff   <= ticks_left_in;
         retries_left_ff <= retries_left_in;
      end
   end

   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(entry_status_ff) && $stable(entry_ip_ff)
                 && $stable(ticks_left_ff) && $stable(retries_left_ff)))
      else $error("entry state changed without an item");

   a_reply_loads_sender: assert property (@(posedge clock) disable iff (reset)
      (fire && result.result_code == RC_REPLY)
      |=> (entry_status_ff == ST_OK && entry_ip_ff == $past(item.src_ip)))
      else $error("reply did not load the entry");

   a_exhausted_frees: assert property (@(posedge clock) disable iff (reset)
      (fire && item.kind == KIND_TICK && entry_status_ff == ST_RESOLVING
       && ticks_dec == '0 && retries_left_ff == '0)
      |=> (entry_status_ff == ST_FREE))
      else $error("resolving entry not freed after last retry");

   a_hit_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (fire && result.result_code == RC_HIT) |-> entry_live_ok)
      else $error("hit reported on an entry that is not ok");

endmodule

// ----- test/arpc_checker.sv -----
// Checker for the single-entry ARP cache engine: watches the item, result and CSR ports,
// predicts each result item on its own copy of the cache entry and compares field by field.
// Depends on arpc_pkg.
module arpc_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  arpc_pkg::item_type  req_item,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [2:0]          rsp_result_code,
   input  logic [31:0]         rsp_out_dst_ip,
   input  logic [47:0]         rsp_out_dst_mac,
   input  logic [47:0]         rsp_found_mac,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [47:0]         csr_wdata,
   output int                  failures,
   output int                  results_owed
);
   import arpc_pkg::*;

   cfg_type                cfg;
   status_type             entry_status;
   logic [IpWidth-1:0]     entry_ip;
   logic [MacWidth-1:0]    entry_mac;
   logic [TickWidth-1:0]   ticks_left;
   logic [RetryWidth-1:0]  retries_left;
   result_type             pending_results[$];
   int                     mismatch_count;

   function automatic result_type arp_outcome(input item_type it);
      result_type r;
      logic accept;
      r = '0;
      case (it.kind)
         KIND_TICK: begin
            if (entry_status != ST_FREE) begin
               ticks_left = ticks_left - TickWidth'(1);
               if (ticks_left == '0) begin
                  if (entry_status == ST_OK || retries_left != '0) begin
                     if (entry_status == ST_RESOLVING)
                        retries_left = retries_left - RetryWidth'(1);
                     entry_status = ST_RESOLVING;
                     ticks_left = cfg.pending_timeout_ticks;
                     r.result_code = RC_REQUEST;
                     r.out_dst_ip = entry_ip;
                  end else begin
                     entry_status = ST_FREE;
                  end
               end
            end
         end
         KIND_FRAME: begin
            accept = it.frame_len >= MIN_FRAME_LEN && it.ethertype == ETHERTYPE_ARP
               && it.hw_type == HW_TYPE_ETH && it.proto_id == PROTO_ID_IPV4
               && it.hw_len == HW_LEN_ETH && it.pro_len == PRO_LEN_IPV4
               && (it.opcode == OP_REQUEST || it.opcode == OP_REPLY)
               && it.dst_ip == cfg.local_ip;
            if (accept) begin
               if (it.opcode == OP_REQUEST) begin
                  r.result_code = RC_REPLY;
                  r.out_dst_ip = it.src_ip;
                  r.out_dst_mac = it.src_mac;
               end
               entry_ip = it.src_ip;
               entry_mac = it.src_mac;
               entry_status = ST_OK;
               ticks_left = cfg.ok_timeout_ticks;
               retries_left = cfg.max_retries;
            end
         end
         KIND_QUERY: begin
            if (entry_status == ST_OK && entry_ip == it.query_ip) begin
               r.result_code = RC_HIT;
               r.found_mac = entry_mac;
            end else begin
               r.result_code = RC_MISS;
               r.out_dst_ip = it.query_ip;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : track
      result_type want;
      if (reset) begin
         cfg.local_mac = '0;
         cfg.local_ip = '0;
         cfg.ok_timeout_ticks = OK_TIMEOUT_RESET;
         cfg.pending_timeout_ticks = PENDING_TIMEOUT_RESET;
         cfg.max_retries = MAX_RETRIES_RESET;
         entry_status = ST_FREE;
         entry_ip = '0;
         entry_mac = '0;
         ticks_left = '0;
         retries_left = '0;
         pending_results.delete();
         mismatch_count = 0;
         failures <= 0;
         results_owed <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LOCAL_MAC:       cfg.local_mac = csr_wdata;
               CSR_LOCAL_IP:        cfg.local_ip = csr_wdata[IpWidth-1:0];
               CSR_OK_TIMEOUT:      cfg.ok_timeout_ticks = csr_wdata[TickWidth-1:0];
               CSR_PENDING_TIMEOUT: cfg.pending_timeout_ticks = csr_wdata[TickWidth-1:0];
               CSR_MAX_RETRIES:     cfg.max_retries = csr_wdata[RetryWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_results.push_back(arp_outcome(req_item));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item: result_code %0d", rsp_result_code);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_code !== want.result_code) begin
                  $error("result_code: expected %0d, got %0d", want.result_code,
                         rsp_result_code);
                  mismatch_count++;
               end
               if (rsp_out_dst_ip !== want.out_dst_ip) begin
                  $error("out_dst_ip: expected %h, got %h", want.out_dst_ip,
                         rsp_out_dst_ip);
                  mismatch_count++;
               end
               if (rsp_out_dst_mac !== want.out_dst_mac) begin
                  $error("out_dst_mac: expected %h, got %h", want.out_dst_mac,
                         rsp_out_dst_mac);
                  mismatch_count++;
               end
               if (rsp_found_mac !== want.found_mac) begin
                  $error("found_mac: expected %h, got %h", want.found_mac, rsp_found_mac);
                  mismatch_count++;
               end
            end
         end
         failures <= mismatch_count;
         results_owed <= pending_results.size();
      end
   end

endmodule

// ----- test/testbench.sv -----
// Top of the ARP cache engine regression: clock, reset, CSR phases, item stimulus with
// bursts and gaps, result-side stalls, timeout and verdict.
// Depends on arpc_pkg, arpc_checker and arp_responder_single_entry_cache_unit.
module testbench;
   import arpc_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int PHASE_ITEMS = 400;
   localparam int HOLD_AFTER_RESULTS = 700;

   typedef enum {READY_FREE, READY_RANDOM, READY_SPARSE, READY_HELD} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   item_type    req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_result_code;
   logic [31:0] rsp_out_dst_ip;
   logic [47:0] rsp_out_dst_mac;
   logic [47:0] rsp_found_mac;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   int          failures;
   int          results_owed;

   logic [IpWidth-1:0] ip_pool[4];
   logic [IpWidth-1:0] own_ip = '0;
   int                 burst_left = 0;

   always #5 clock = ~clock;

   arp_responder_single_entry_cache_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_item.kind),
      .req_ethertype   (req_item.ethertype),
      .req_frame_len   (req_item.frame_len),
      .req_hw_type     (req_item.hw_type),
      .req_proto_id    (req_item.proto_id),
      .req_hw_len      (req_item.hw_len),
      .req_pro_len     (req_item.pro_len),
      .req_opcode      (req_item.opcode),
      .req_src_mac     (req_item.src_mac),
      .req_src_ip      (req_item.src_ip),
      .req_dst_ip      (req_item.dst_ip),
      .req_query_ip    (req_item.query_ip),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_code (rsp_result_code),
      .rsp_out_dst_ip  (rsp_out_dst_ip),
      .rsp_out_dst_mac (rsp_out_dst_mac),
      .rsp_found_mac   (rsp_found_mac),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   arpc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_code (rsp_result_code),
      .rsp_out_dst_ip  (rsp_out_dst_ip),
      .rsp_out_dst_mac (rsp_out_dst_mac),
      .rsp_found_mac   (rsp_found_mac),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .results_owed    (results_owed)
   );

   function automatic item_type arp_frame(input logic [15:0] op, input logic [31:0] sip,
                                          input logic [47:0] smac, input logic [31:0] tip);
      item_type it;
      it = '0;
      it.kind = KIND_FRAME;
      it.ethertype = ETHERTYPE_ARP;
      it.frame_len = MIN_FRAME_LEN;
      it.hw_type = HW_TYPE_ETH;
      it.proto_id = PROTO_ID_IPV4;
      it.hw_len = HW_LEN_ETH;
      it.pro_len = PRO_LEN_IPV4;
      it.opcode = op;
      it.src_mac = smac;
      it.src_ip = sip;
      it.dst_ip = tip;
      return it;
   endfunction

   function automatic item_type simple_item(input logic [1:0] kind, input logic [31:0] qip);
      item_type it;
      it = '0;
      it.kind = kind;
      it.query_ip = qip;
      return it;
   endfunction

   function automatic item_type random_item();
      item_type it;
      logic [63:0] wide;
      int pick;
      wide = {$urandom, $urandom};
      it.kind = 2'($urandom_range(0, 3));
      it.ethertype = 16'($urandom_range(0, 16'hFFFF));
      it.frame_len = 11'($urandom_range(0, 2047));
      it.hw_type = 16'($urandom_range(0, 16'hFFFF));
      it.proto_id = 16'($urandom_range(0, 16'hFFFF));
      it.hw_len = 8'($urandom_range(0, 255));
      it.pro_len = 8'($urandom_range(0, 255));
      it.opcode = 16'($urandom_range(0, 16'hFFFF));
      it.src_mac = wide[47:0];
      it.src_ip = $urandom;
      it.dst_ip = $urandom;
      it.query_ip = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.kind = KIND_TICK;
      end else if (pick < 78) begin
         it.kind = KIND_FRAME;
         it.ethertype = ETHERTYPE_ARP;
         it.frame_len = 11'($urandom_range(MIN_FRAME_LEN, 2047));
         it.hw_type = HW_TYPE_ETH;
         it.proto_id = PROTO_ID_IPV4;
         it.hw_len = HW_LEN_ETH;
         it.pro_len = PRO_LEN_IPV4;
         it.opcode = $urandom_range(0, 1) ? OP_REQUEST : OP_REPLY;
         if ($urandom_range(0, 4) != 0)
            it.src_ip = ip_pool[2'($urandom_range(0, 3))];
         it.dst_ip = own_ip;
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 7))
               0: it.frame_len = 11'($urandom_range(0, MIN_FRAME_LEN - 11'd1));
               1: it.ethertype = 16'($urandom_range(0, 16'hFFFF));
               2: it.hw_type = 16'($urandom_range(0, 16'hFFFF));
               3: it.proto_id = 16'($urandom_range(0, 16'hFFFF));
               4: it.hw_len = 8'($urandom_range(0, 255));
               5: it.pro_len = 8'($urandom_range(0, 255));
               6: it.opcode = 16'($urandom_range(0, 16'hFFFF));
               default: it.dst_ip = $urandom;
            endcase
         end
      end else if (pick < 96) begin
         it.kind = KIND_QUERY;
         if ($urandom_range(0, 3) != 0)
            it.query_ip = ip_pool[2'($urandom_range(0, 3))];
      end else begin
         it.kind = KIND_RESERVED;
      end
      return it;
   endfunction

   task automatic offer(input item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(0, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_cfg(input cfg_type c);
      write_reg(CSR_LOCAL_MAC, c.local_mac);
      write_reg(CSR_LOCAL_IP, 48'(c.local_ip));
      write_reg(CSR_OK_TIMEOUT, 48'(c.ok_timeout_ticks));
      write_reg(CSR_PENDING_TIMEOUT, 48'(c.pending_timeout_ticks));
      write_reg(CSR_MAX_RETRIES, 48'(c.max_retries));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      own_ip = c.local_ip;
   endtask

   initial begin : receiver
      ready_mode_type mode;
      int span;
      int seen;
      bit held;
      seen = 0;
      held = 0;
      forever begin
         mode = ready_mode_type'($urandom_range(0, 2));
         span = $urandom_range(1, 40);
         if (!held && seen >= HOLD_AFTER_RESULTS) begin
            held = 1;
            mode = READY_HELD;
            span = 300;
         end
         repeat (span) begin
            @(posedge clock);
            if (rsp_valid && rsp_ready)
               seen++;
            case (mode)
               READY_FREE:   rsp_ready <= 1'b1;
               READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= 1'b0;
            endcase
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      cfg_type c;
      logic [63:0] wide;
      item_type it;
      logic [31:0] ip_a;
      logic [31:0] ip_b;
      logic [47:0] mac_a;
      ip_a = 32'h0A00_0102;
      ip_b = 32'hC0A8_0063;
      mac_a = 48'h0200_1234_5678;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: local IP 0, default timeouts
      offer(simple_item(KIND_TICK, '0));
      offer(simple_item(KIND_QUERY, '0));
      offer(arp_frame(OP_REQUEST, ip_a, mac_a, '0));
      offer(simple_item(KIND_QUERY, ip_a));
      settle();

      c.local_mac = '1;
      c.local_ip = 32'hC0A8_0001;
      c.ok_timeout_ticks = 16'd2;
      c.pending_timeout_ticks = 16'd1;
      c.max_retries = 8'd1;
      write_cfg(c);
      it = arp_frame(OP_REQUEST, ip_b, mac_a, own_ip);
      it.frame_len = MIN_FRAME_LEN - 11'd1;
      offer(it);
      it = arp_frame(OP_REQUEST, ip_b, mac_a, own_ip);
      it.ethertype = PROTO_ID_IPV4;
      offer(it);
      it = arp_frame(OP_REQUEST, ip_b, mac_a, own_ip);
      it.hw_type = 16'd6;
      offer(it);
      it = arp_frame(OP_REQUEST, ip_b, mac_a, own_ip);
      it.proto_id = 16'h86DD;
      offer(it);
      it = arp_frame(OP_REQUEST, ip_b, mac_a, own_ip);
      it.hw_len = 8'd8;
      offer(it);
      it = arp_frame(OP_REQUEST, ip_b, mac_a, own_ip);
      it.pro_len = 8'd16;
      offer(it);
      offer(arp_frame(16'd0, ip_b, mac_a, own_ip));
      offer(arp_frame(16'd3, ip_b, mac_a, own_ip));
      offer(arp_frame(OP_REQUEST, ip_b, mac_a, '0));
      offer(simple_item(KIND_QUERY, ip_a));
      it = arp_frame(OP_REPLY, ip_b, '1, own_ip);
      it.frame_len = 11'd2047;
      offer(it);
      offer(simple_item(KIND_RESERVED, ip_b));
      offer(simple_item(KIND_TICK, '0));
      offer(simple_item(KIND_TICK, '0));
      offer(simple_item(KIND_QUERY, ip_b));
      offer(simple_item(KIND_TICK, '0));
      offer(simple_item(KIND_TICK, '0));
      offer(simple_item(KIND_TICK, '0));
      offer(arp_frame(OP_REQUEST, '0, '0, own_ip));
      offer(simple_item(KIND_QUERY, '0));

      for (int p = 0; p < 5; p++) begin
         wide = {$urandom, $urandom};
         c.local_mac = wide[47:0];
         c.local_ip = $urandom;
         case (p)
            0: begin
               c.local_mac = '1;
               c.local_ip = '1;
               c.ok_timeout_ticks = 16'd1;
               c.pending_timeout_ticks = 16'd1;
               c.max_retries = 8'd0;
            end
            1: begin
               c.local_mac = '0;
               c.local_ip = '0;
               c.ok_timeout_ticks = 16'd3;
               c.pending_timeout_ticks = 16'd2;
               c.max_retries = 8'd255;
            end
            2: begin
               c.ok_timeout_ticks = 16'hFFFF;
               c.pending_timeout_ticks = 16'hFFFF;
               c.max_retries = 8'd3;
            end
            3: begin
               c.ok_timeout_ticks = 16'd0;
               c.pending_timeout_ticks = 16'd0;
               c.max_retries = 8'd1;
            end
            default: begin
               c.ok_timeout_ticks = 16'($urandom_range(2, 8));
               c.pending_timeout_ticks = 16'($urandom_range(1, 4));
               c.max_retries = 8'($urandom_range(0, 3));
            end
         endcase
         settle();
         write_cfg(c);
         ip_pool[0] = $urandom;
         ip_pool[1] = $urandom;
         ip_pool[2] = '0;
         ip_pool[3] = '1;
         repeat (PHASE_ITEMS) offer(random_item());
      end

      settle();
      repeat (6) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
